>>> src/mtsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsc_pkg
// shared widths, unit status type and curve table helpers
// ----------------------------------------------------------------------------
package mtsc_pkg;

  localparam int TIME_BITS_DEF   = 48;
  localparam int CURVE_DEPTH_DEF = 64;

  // beat field widths
  localparam int MOTION_W = 24;
  localparam int WHEEL_W  = 16;
  localparam int STAMP_W  = 48;
  localparam int BYTE_W   = 8;

  // shared unit sizes
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 32;
  localparam int SQRT_RAD_W = 64;

  typedef struct packed {
    logic busy;
    logic done;
  } mtsc_unit_stat_t;

  // floor square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] r;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    r   = v;
    for (int k = 0; k < 32; k++) begin
      if (r >= res + b) begin
        r   = r - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // q^1.25 in q16, q given in q16
  function automatic logic [16:0] curve_of_q(input logic [63:0] q);
    logic [63:0] t;
    logic [63:0] p;
    t = isqrt64(isqrt64(q << 16) << 16);
    p = q * t;
    return p[32:16];
  endfunction

endpackage

>>> src/mtsc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsc channel interfaces
// frame beat in, stick beat out, valid/ready handshake
// ----------------------------------------------------------------------------
interface mtsc_in_if;
  import mtsc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [MOTION_W-1:0] motion_x;
  logic signed [MOTION_W-1:0] motion_y;
  logic signed [WHEEL_W-1:0]  wheel_delta;
  logic [STAMP_W-1:0]         time_now;
  logic [BYTE_W-1:0]          stick_x_in;
  logic [BYTE_W-1:0]          stick_y_in;
  modport source (output valid, motion_x, motion_y, wheel_delta, time_now,
                  stick_x_in, stick_y_in, input ready);
  modport sink (input valid, motion_x, motion_y, wheel_delta, time_now,
                stick_x_in, stick_y_in, output ready);
endinterface

interface mtsc_out_if;
  import mtsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stick_x_out;
  logic [BYTE_W-1:0] stick_y_out;
  modport source (output valid, stick_x_out, stick_y_out, input ready);
  modport sink (input valid, stick_x_out, stick_y_out, output ready);
endinterface

>>> src/mouse_to_stick_converter.sv
`timescale 1ns / 1ps
// sequencing: a moving frame passes three divider waits and one square-root wait
//   on its way to the stick beat; a still frame (or zero sensitivity) skips them;
//   the beat may also wait for the previous beat to leave the output register
// throughput: one frame at a time; a new frame is taken only once the last beat
//   has been loaded into the output register
// reset: synchronous, clears sequencer, smoothing, wheel and pulse state and
//   loads the register defaults; a result beat that waits is dropped
// ----------------------------------------------------------------------------
// mouse_to_stick_converter
// per-frame mouse and wheel to analogue stick conversion with curve shaping,
// anti-deadzone, exponential smoothing and queued wheel pulses
// ----------------------------------------------------------------------------
module mouse_to_stick_converter #(
  parameter int TIME_BITS         = mtsc_pkg::TIME_BITS_DEF,
  parameter int CURVE_TABLE_DEPTH = mtsc_pkg::CURVE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data,
  mtsc_in_if.sink     frame_in,
  mtsc_out_if.source  stick_out
);
  import mtsc_pkg::*;

  // register map
  localparam logic [2:0] REG_SENS  = 3'd0;
  localparam logic [2:0] REG_ADZ   = 3'd1;
  localparam logic [2:0] REG_SMW   = 3'd2;
  localparam logic [2:0] REG_PLEN  = 3'd3;
  localparam logic [2:0] REG_PLIM  = 3'd4;

  // pulse direction codes
  localparam logic [1:0] PD_NONE = 2'd0;
  localparam logic [1:0] PD_UP   = 2'd1;
  localparam logic [1:0] PD_DOWN = 2'd2;

  // sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_MDX    = 5'd1;
  localparam logic [4:0] ST_MDY    = 5'd2;
  localparam logic [4:0] ST_MS90   = 5'd3;
  localparam logic [4:0] ST_SQRT   = 5'd4;
  localparam logic [4:0] ST_ROOTW  = 5'd5;
  localparam logic [4:0] ST_MR     = 5'd6;
  localparam logic [4:0] ST_MDIV   = 5'd7;
  localparam logic [4:0] ST_MDIVW  = 5'd8;
  localparam logic [4:0] ST_INTERP = 5'd9;
  localparam logic [4:0] ST_CURVE  = 5'd10;
  localparam logic [4:0] ST_TGT    = 5'd11;
  localparam logic [4:0] ST_TGTR   = 5'd12;
  localparam logic [4:0] ST_DIVX   = 5'd13;
  localparam logic [4:0] ST_OX     = 5'd14;
  localparam logic [4:0] ST_OXR    = 5'd15;
  localparam logic [4:0] ST_DIVY   = 5'd16;
  localparam logic [4:0] ST_OY     = 5'd17;
  localparam logic [4:0] ST_OYR    = 5'd18;
  localparam logic [4:0] ST_SX1    = 5'd19;
  localparam logic [4:0] ST_SX2    = 5'd20;
  localparam logic [4:0] ST_SX3    = 5'd21;
  localparam logic [4:0] ST_SY1    = 5'd22;
  localparam logic [4:0] ST_SY2    = 5'd23;
  localparam logic [4:0] ST_SY3    = 5'd24;
  localparam logic [4:0] ST_WH1    = 5'd25;
  localparam logic [4:0] ST_WH2    = 5'd26;
  localparam logic [4:0] ST_WH3    = 5'd27;
  localparam logic [4:0] ST_WH4    = 5'd28;
  localparam logic [4:0] ST_DONE   = 5'd29;

  localparam int IDXW = $clog2(CURVE_TABLE_DEPTH + 1);
  localparam int POSW = 16 + IDXW;
  localparam int ROOT_W = SQRT_RAD_W / 2;

  localparam logic [16:0] DT_FIRST = 17'd4000;
  localparam logic [16:0] DT_MIN   = 17'd500;
  localparam logic [16:0] DT_MAX   = 17'd100000;
  localparam logic [16:0] Q16_ONE  = 17'h10000;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // curve table, built at elaboration
  logic [16:0] curve_tab [CURVE_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= CURVE_TABLE_DEPTH; gi++) begin : g_curve
    localparam logic [63:0] CQ = (64'(gi) << 16) / CURVE_TABLE_DEPTH;
    assign curve_tab[gi] = curve_of_q(CQ);
  end

  // configuration
  logic [15:0] sens;
  logic [15:0] adz;
  logic [15:0] smw;
  logic [19:0] plen;
  logic [21:0] plim;

  // persistent state
  logic [TIME_BITS-1:0] last_time;
  logic signed [15:0]   smx;
  logic signed [15:0]   smy;
  logic signed [7:0]    wrem;
  logic [1:0]           pdir;
  logic [TIME_BITS-1:0] pend;

  // sequencer and per-frame working registers
  logic [4:0]           state;
  logic signed [MOTION_W-1:0] dx;
  logic signed [MOTION_W-1:0] dy;
  logic signed [WHEEL_W-1:0]  wheel;
  logic [TIME_BITS-1:0] now_us;
  logic [7:0]           sx_in;
  logic [7:0]           sy_in;
  logic [16:0]          dt;
  logic [47:0]          sq;
  logic [23:0]          s90;
  logic [ROOT_W-1:0]    r8;
  logic [16:0]          msat;
  logic [16:0]          cv_a;
  logic                 top_seg;
  logic [16:0]          curved;
  logic [16:0]          target;
  logic [15:0]          ux;
  logic signed [16:0]   ox;
  logic signed [16:0]   oy;
  logic signed [35:0]   acc;
  logic [3:0]           steps_n;
  logic                 steps_up;
  logic [TIME_BITS-1:0] e1;
  logic [TIME_BITS-1:0] e2;

  // shared multiplier
  logic signed [32:0]   mul_a;
  logic signed [24:0]   mul_b;
  logic signed [57:0]   prod;

  // output register
  logic                 out_valid;
  logic [7:0]           out_x;
  logic [7:0]           out_y;

  // shared units
  logic                 sqrt_start;
  logic [ROOT_W-1:0]    sqrt_root;
  mtsc_unit_stat_t      sqrt_stat;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quot;
  mtsc_unit_stat_t      div_stat;

  mtsc_sqrt #(.RAD_W(SQRT_RAD_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   ({sq, 16'b0}),
    .root  (sqrt_root),
    .stat  (sqrt_stat)
  );

  mtsc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // stick byte of a q1.15 value
  function automatic logic [7:0] to_byte(input logic signed [15:0] s);
    logic signed [24:0] t;
    t = 25'(s) * 25'sd127 + 25'sd4210688;
    return (t[23:15] > 9'd255) ? 8'd255 : t[22:15];
  endfunction

  // frame time from the incoming stamp
  logic [TIME_BITS-1:0] now_in;
  logic [TIME_BITS-1:0] dt_raw;
  logic [16:0]          dt_in;
  always_comb begin
    now_in = TIME_BITS'(frame_in.time_now);
    dt_raw = (last_time != '0) ? now_in - last_time : TIME_BITS'(DT_FIRST);
    if (dt_raw < TIME_BITS'(DT_MIN)) dt_in = DT_MIN;
    else if (dt_raw > TIME_BITS'(DT_MAX)) dt_in = DT_MAX;
    else dt_in = dt_raw[16:0];
  end

  // curve position and table reads
  logic [POSW-1:0] pos;
  logic [IDXW-1:0] idx;
  logic [IDXW-1:0] idx_b;
  logic            seg_top;
  logic [16:0]     cv_lo;
  logic [16:0]     cv_hi;
  always_comb begin
    pos     = POSW'(msat) * POSW'(CURVE_TABLE_DEPTH);
    idx     = pos[POSW-1:16];
    seg_top = idx >= IDXW'(CURVE_TABLE_DEPTH);
    idx_b   = seg_top ? idx : idx + 1'b1;
    cv_lo   = curve_tab[idx];
    cv_hi   = curve_tab[idx_b];
  end

  logic moving;
  assign moving = ((dx != '0) || (dy != '0)) && (sens != '0);

  logic [MOTION_W-1:0] adx;
  logic [MOTION_W-1:0] ady;
  assign adx = dx[MOTION_W-1] ? MOTION_W'(-dx) : MOTION_W'(dx);
  assign ady = dy[MOTION_W-1] ? MOTION_W'(-dy) : MOTION_W'(dy);

  // multiplier operand select
  always_comb begin
    case (state)
      ST_MDX: begin
        mul_a = 33'(dx);
        mul_b = 25'(dx);
      end
      ST_MDY: begin
        mul_a = 33'(dy);
        mul_b = 25'(dy);
      end
      ST_MS90: begin
        mul_a = {17'b0, sens};
        mul_b = 25'sd90;
      end
      ST_MR: begin
        mul_a = {1'b0, r8};
        mul_b = {1'b0, s90};
      end
      ST_INTERP: begin
        mul_a = {16'b0, cv_hi - cv_lo};
        mul_b = {9'b0, pos[15:0]};
      end
      ST_TGT: begin
        mul_a = {16'b0, Q16_ONE - {1'b0, adz}};
        mul_b = {8'b0, curved};
      end
      ST_OX, ST_OY: begin
        mul_a = {17'b0, ux};
        mul_b = {8'b0, target};
      end
      ST_SX1: begin
        mul_a = {17'b0, smw};
        mul_b = 25'(ox);
      end
      ST_SX2: begin
        mul_a = {16'b0, Q16_ONE - {1'b0, smw}};
        mul_b = 25'(smx);
      end
      ST_SY1: begin
        mul_a = {17'b0, smw};
        mul_b = 25'(oy);
      end
      ST_SY2: begin
        mul_a = {16'b0, Q16_ONE - {1'b0, smw}};
        mul_b = 25'(smy);
      end
      ST_WH2: begin
        mul_a = {13'b0, plen};
        mul_b = {21'b0, steps_n};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // unit starts and operands
  always_comb begin
    sqrt_start = (state == ST_SQRT) && moving;
    div_start  = (state == ST_MDIV) || (state == ST_TGTR) || (state == ST_OXR);
    case (state)
      ST_MDIV: begin
        div_num = prod[DIV_NUM_W-1:0];
        div_den = DIV_DEN_W'(dt);
      end
      ST_TGTR: begin
        div_num = {9'b0, adx, 23'b0};
        div_den = DIV_DEN_W'(r8);
      end
      default: begin
        div_num = {9'b0, ady, 23'b0};
        div_den = DIV_DEN_W'(r8);
      end
    endcase
  end

  // rounded magnitude of u * target
  logic [33:0] mag_sum;
  logic [16:0] mag;
  assign mag_sum = prod[33:0] + 34'd32768;
  assign mag     = mag_sum[32:16];

  // smoothing result
  logic signed [35:0] sm_sum;
  logic signed [19:0] sm_r;
  logic signed [15:0] sm_clamp;
  always_comb begin
    sm_sum = acc + prod[35:0] + 36'sd32768;
    sm_r   = 20'(sm_sum >>> 16);
    if (sm_r > 20'sd32767) sm_clamp = 16'sd32767;
    else if (sm_r < -20'sd32768) sm_clamp = -16'sd32768;
    else sm_clamp = sm_r[15:0];
  end

  // wheel detents: at most eight per frame
  logic signed [16:0] rem_sum;
  logic signed [10:0] rem_c;
  logic               rem_neg;
  logic [9:0]         rem_abs;
  logic [3:0]         n_det;
  logic [9:0]         rem_left;
  always_comb begin
    rem_sum = 17'(wheel) + 17'(wrem);
    if (rem_sum > 17'sd960) rem_c = 11'sd960;
    else if (rem_sum < -17'sd960) rem_c = -11'sd960;
    else rem_c = rem_sum[10:0];
    rem_neg = rem_c[10];
    rem_abs = rem_neg ? 10'(-rem_c) : 10'(rem_c);
    n_det   = '0;
    for (int k = 1; k <= 8; k++) begin
      if (rem_abs >= 10'(k * 120)) n_det = n_det + 1'b1;
    end
    rem_left = rem_abs - 10'(n_det * 7'd120);
  end

  // pulse end candidates
  logic [1:0]           new_dir;
  logic [TIME_BITS-1:0] pbase;
  logic [TIME_BITS:0]   e1_sum;
  logic [TIME_BITS:0]   e2_sum;
  always_comb begin
    new_dir = steps_up ? PD_UP : PD_DOWN;
    pbase   = (pdir == new_dir && pend > now_us) ? pend : now_us;
    e1_sum  = {1'b0, pbase} + (TIME_BITS+1)'(prod[22:0]);
    e2_sum  = {1'b0, now_us} + (TIME_BITS+1)'(plim);
  end

  logic [1:0]           pdir_n;
  logic [TIME_BITS-1:0] pend_n;
  always_comb begin
    pdir_n = pdir;
    pend_n = pend;
    if (steps_n != '0) begin
      pdir_n = new_dir;
      pend_n = (e1 < e2) ? e1 : e2;
    end
    if (pend_n <= now_us) pdir_n = PD_NONE;
  end

  // final bytes, neutral axes take the generated value
  logic [7:0] byte_x;
  logic [7:0] byte_y;
  always_comb begin
    byte_x = (sx_in != 8'd128) ? sx_in : to_byte(smx);
    if (sy_in != 8'd128) byte_y = sy_in;
    else if (pdir == PD_UP) byte_y = 8'd0;
    else if (pdir == PD_DOWN) byte_y = 8'd255;
    else byte_y = to_byte(smy);
  end

  logic out_free;
  assign out_free = !out_valid || stick_out.ready;

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sens      <= 16'd256;
      adz       <= 16'd7864;
      smw       <= 16'd45875;
      plen      <= 20'd70000;
      plim      <= 22'd280000;
      last_time <= '0;
      smx       <= '0;
      smy       <= '0;
      wrem      <= '0;
      pdir      <= PD_NONE;
      pend      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SENS: sens <= cfg_data[15:0];
          REG_ADZ:  adz  <= cfg_data[15:0];
          REG_SMW:  smw  <= cfg_data[15:0];
          REG_PLEN: plen <= cfg_data[19:0];
          REG_PLIM: plim <= cfg_data[21:0];
          default: ;
        endcase
      end
      // the done state loads the register itself
      if (out_valid && stick_out.ready && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (frame_in.valid) begin
            last_time <= now_in;
            state     <= ST_MDX;
          end
        end
        ST_MDX:   state <= ST_MDY;
        ST_MDY:   state <= ST_MS90;
        ST_MS90:  state <= ST_SQRT;
        ST_SQRT:  state <= moving ? ST_ROOTW : ST_SX1;
        ST_ROOTW: if (sqrt_stat.done) state <= ST_MR;
        ST_MR:    state <= ST_MDIV;
        ST_MDIV:  state <= ST_MDIVW;
        ST_MDIVW: if (div_stat.done) state <= ST_INTERP;
        ST_INTERP: state <= ST_CURVE;
        ST_CURVE: state <= ST_TGT;
        ST_TGT:   state <= ST_TGTR;
        ST_TGTR:  state <= ST_DIVX;
        ST_DIVX:  if (div_stat.done) state <= ST_OX;
        ST_OX:    state <= ST_OXR;
        ST_OXR:   state <= ST_DIVY;
        ST_DIVY:  if (div_stat.done) state <= ST_OY;
        ST_OY:    state <= ST_OYR;
        ST_OYR:   state <= ST_SX1;
        ST_SX1:   state <= ST_SX2;
        ST_SX2:   state <= ST_SX3;
        ST_SX3: begin
          smx   <= sm_clamp;
          state <= ST_SY1;
        end
        ST_SY1:   state <= ST_SY2;
        ST_SY2:   state <= ST_SY3;
        ST_SY3: begin
          smy   <= sm_clamp;
          state <= ST_WH1;
        end
        ST_WH1: begin
          wrem  <= rem_neg ? -8'(rem_left) : 8'(rem_left);
          state <= ST_WH2;
        end
        ST_WH2:   state <= ST_WH3;
        ST_WH3:   state <= ST_WH4;
        ST_WH4: begin
          pdir  <= pdir_n;
          pend  <= pend_n;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold here while the previous beat still waits
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dx     <= frame_in.motion_x;
        dy     <= frame_in.motion_y;
        wheel  <= frame_in.wheel_delta;
        now_us <= now_in;
        sx_in  <= frame_in.stick_x_in;
        sy_in  <= frame_in.stick_y_in;
        dt     <= dt_in;
      end
      ST_MDY:  sq <= prod[47:0];
      ST_MS90: sq <= sq + prod[47:0];
      ST_SQRT: begin
        s90 <= prod[23:0];
        if (!moving) begin
          ox <= '0;
          oy <= '0;
        end
      end
      ST_ROOTW: r8 <= sqrt_root;
      ST_MDIVW: msat <= (div_quot > DIV_NUM_W'(Q16_ONE)) ? Q16_ONE : div_quot[16:0];
      ST_INTERP: begin
        cv_a    <= cv_lo;
        top_seg <= seg_top;
      end
      ST_CURVE: curved <= top_seg ? curve_tab[CURVE_TABLE_DEPTH] : cv_a + prod[32:16];
      ST_TGTR:  target <= {1'b0, adz} + prod[32:16];
      ST_DIVX, ST_DIVY: begin
        ux <= (div_quot > DIV_NUM_W'(32768)) ? 16'd32768 : div_quot[15:0];
      end
      ST_OXR: ox <= dx[MOTION_W-1] ? -$signed(mag) : $signed(mag);
      ST_OYR: oy <= dy[MOTION_W-1] ? -$signed(mag) : $signed(mag);
      ST_SX2, ST_SY2: acc <= prod[35:0];
      ST_WH1: begin
        steps_n  <= n_det;
        steps_up <= !rem_neg;
      end
      ST_WH3: begin
        e1 <= e1_sum[TIME_BITS] ? TIME_MAX : e1_sum[TIME_BITS-1:0];
        e2 <= e2_sum[TIME_BITS] ? TIME_MAX : e2_sum[TIME_BITS-1:0];
      end
      ST_DONE: begin
        if (out_free) begin
          out_x <= byte_x;
          out_y <= byte_y;
        end
      end
      default: ;
    endcase
  end

  assign frame_in.ready        = (state == ST_IDLE);
  assign stick_out.valid       = out_valid;
  assign stick_out.stick_x_out = out_x;
  assign stick_out.stick_y_out = out_y;

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    frame_in.valid && frame_in.ready |=> state != ST_IDLE)
    else $error("sequencer did not start on an accepted beat");

  a_wheel_rem_range: assert property (@(posedge clk) disable iff (rst)
    wrem > -8'sd120 && wrem < 8'sd120)
    else $error("wheel remainder holds a whole detent");

  a_pulse_dir_code: assert property (@(posedge clk) disable iff (rst)
    pdir != 2'd3)
    else $error("pulse direction holds an unused code");

  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> stick_out.valid && state == ST_IDLE)
    else $error("finished frame did not reach the output register");
`endif

endmodule

>>> src/mtsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mtsc_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]          den,
  output logic [NUM_W-1:0]          quot,
  output mtsc_pkg::mtsc_unit_stat_t stat
);
  import mtsc_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0] work;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem[DEN_W-1:0], work[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      work <= {work[NUM_W-2:0], ge};
      rem  <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
    end
  end

  assign quot      = work;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> src/mtsc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsc_sqrt
// restoring floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module mtsc_sqrt #(
  parameter int RAD_W = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [RAD_W-1:0]          rad,
  output logic [RAD_W/2-1:0]        root,
  output mtsc_pkg::mtsc_unit_stat_t stat
);
  import mtsc_pkg::*;

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CW     = $clog2(ROOT_W);

  logic [RAD_W-1:0]  work;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] res;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], work[RAD_W-1:RAD_W-2]};
    trial  = {1'b0, res, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= rad;
      rem  <= '0;
      res  <= '0;
    end else if (busy) begin
      work <= {work[RAD_W-3:0], 2'b00};
      rem  <= ge ? rem_sh - trial : rem_sh;
      res  <= {res[ROOT_W-2:0], ge};
    end
  end

  assign root      = res;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> test/tb_mouse_to_stick_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mouse_to_stick_converter
// drives frame beats through the converter under random back-pressure and
// checks every stick beat against a local model of the gain, curve, smoothing
// and wheel pulse logic or hand-set bytes, across several register settings
// ----------------------------------------------------------------------------
module tb_mouse_to_stick_converter;
  import mtsc_pkg::*;

  // register indexes
  localparam logic [2:0] REG_SENS    = 3'd0;
  localparam logic [2:0] REG_ADZ     = 3'd1;
  localparam logic [2:0] REG_WEIGHT  = 3'd2;
  localparam logic [2:0] REG_PLEN    = 3'd3;
  localparam logic [2:0] REG_QLIMIT  = 3'd4;
  localparam logic [2:0] REG_UNUSED  = 3'd5;

  localparam int DEPTH        = 64;
  localparam longint unsigned STAMP_MASK = 64'h0000_FFFF_FFFF_FFFF;
  localparam int SETTLE       = 400;       // cycles past the last beat
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int PHASE_ITEMS  = 320;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [21:0] cfg_data;

  mtsc_in_if  frame_if ();
  mtsc_out_if stick_if ();

  mouse_to_stick_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame_in  (frame_if),
    .stick_out (stick_if)
  );

  typedef struct {
    logic signed [MOTION_W-1:0] mx;
    logic signed [MOTION_W-1:0] my;
    logic signed [WHEEL_W-1:0]  wh;
    logic [STAMP_W-1:0]         stamp;
    logic [BYTE_W-1:0]          sx;
    logic [BYTE_W-1:0]          sy;
    bit                         typed;   // stick bytes known by inspection
    logic [BYTE_W-1:0]          ex;
    logic [BYTE_W-1:0]          ey;
  } frame_row_t;

  typedef struct {
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] y;
  } stick_pair_t;

  frame_row_t  directed_rows[$];
  frame_row_t  typed_fifo[$];      // row per beat sent, in order
  stick_pair_t expected_sticks[$];

  int err_count;
  int cycles = 0;
  int send_idle;
  int recv_idle;

  // local copy of registers
  longint unsigned gain_cfg, floor_cfg, weight_cfg, plen_cfg, qlimit_cfg;
  // local copy of converter state
  longint unsigned last_stamp, pulse_until;
  int glide_x, glide_y, wheel_left, pulse_dir;
  longint unsigned shape_tab[0:DEPTH];

  // ---------------------------------------------------------------- clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------- model helpers
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int glide(int prev, longint o);
    longint w;
    longint acc;
    longint r;
    w   = longint'(weight_cfg);
    acc = w * o + (65536 - w) * longint'(prev);
    r   = ((acc + 64'sd2147483648 + 64'sd32768) >>> 16) - 64'sd32768;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  function automatic logic [7:0] q15_to_byte(int s);
    longint t;
    t = longint'(s) * 127 + 128 * 32768 + 16384;
    t = t >>> 15;
    return (t > 255) ? 8'd255 : t[7:0];
  endfunction

  function automatic longint axis_push(longint d, longint unsigned r8,
                                       longint unsigned target);
    longint unsigned ad;
    longint unsigned u;
    longint unsigned mag;
    ad  = (d < 0) ? longint'(-d) : longint'(d);
    u   = (ad << 23) / r8;
    if (u > 32768) u = 32768;
    mag = (u * target + 32768) >> 16;
    return (d < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned stamp_add(longint unsigned a, longint unsigned b);
    longint unsigned r;
    r = a + b;
    return (r < a || r > STAMP_MASK) ? STAMP_MASK : r;
  endfunction

  // one frame through the model: updates state, returns the stick bytes
  function automatic stick_pair_t convert_frame(frame_row_t f);
    longint dx, dy, wh, ox, oy, rem, steps;
    longint unsigned now, dt, sq, r8, m, pos, idx, frac, curved, target;
    longint unsigned n, base, e1, e2;
    int dir;
    stick_pair_t res;
    dx  = longint'(f.mx);
    dy  = longint'(f.my);
    wh  = longint'(f.wh);
    now = longint'(f.stamp);
    ox  = 0;
    oy  = 0;

    dt = (last_stamp != 0) ? ((now - last_stamp) & STAMP_MASK) : 4000;
    last_stamp = now;
    if (dt < 500) dt = 500;
    if (dt > 100000) dt = 100000;

    if ((dx != 0 || dy != 0) && gain_cfg != 0) begin
      sq = longint'(dx * dx) + longint'(dy * dy);
      r8 = floor_root(sq << 16);
      m  = r8 * 90 * gain_cfg / dt;
      if (m > 65536) m = 65536;
      pos  = m * DEPTH;
      idx  = pos >> 16;
      frac = pos & 64'hFFFF;
      if (idx >= DEPTH) curved = shape_tab[DEPTH];
      else curved = shape_tab[idx] + (((shape_tab[idx+1] - shape_tab[idx]) * frac) >> 16);
      target = floor_cfg + (((65536 - floor_cfg) * curved) >> 16);
      ox = axis_push(dx, r8, target);
      oy = axis_push(dy, r8, target);
    end

    glide_x = glide(glide_x, ox);
    glide_y = glide(glide_y, oy);

    // wheel detents, remainder kept with its sign
    rem = longint'(wheel_left) + wh;
    if (rem > 960) rem = 960;
    if (rem < -960) rem = -960;
    steps = rem / 120;
    rem   = rem - steps * 120;
    wheel_left = int'(rem);

    if (steps != 0) begin
      dir  = (steps > 0) ? 1 : 2;
      n    = (steps > 0) ? steps : -steps;
      base = (pulse_dir == dir && pulse_until > now) ? pulse_until : now;
      e1   = stamp_add(base, n * plen_cfg);
      e2   = stamp_add(now, qlimit_cfg);
      pulse_dir   = dir;
      pulse_until = (e1 < e2) ? e1 : e2;
    end
    if (pulse_until <= now) pulse_dir = 0;

    res.x = (f.sx != 8'd128) ? f.sx : q15_to_byte(glide_x);
    if (f.sy != 8'd128) res.y = f.sy;
    else if (pulse_dir == 1) res.y = 8'd0;
    else if (pulse_dir == 2) res.y = 8'd255;
    else res.y = q15_to_byte(glide_y);
    return res;
  endfunction

  // ------------------------------------------------------------ reporting
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
    err_count++;
  endtask

  // ------------------------------------------------------------- monitors
  // every accepted frame beat gets its expected stick pair
  always @(posedge clk) begin
    frame_row_t  f;
    stick_pair_t p;
    if (!rst && frame_if.valid && frame_if.ready) begin
      f = typed_fifo.pop_front();
      f.mx = frame_if.motion_x;
      f.my = frame_if.motion_y;
      f.wh = frame_if.wheel_delta;
      f.stamp = frame_if.time_now;
      f.sx = frame_if.stick_x_in;
      f.sy = frame_if.stick_y_in;
      p = convert_frame(f);
      if (f.typed) begin
        p.x = f.ex;
        p.y = f.ey;
      end
      expected_sticks.push_back(p);
    end
  end

  // stick beats against the oldest expectation
  always @(posedge clk) begin
    stick_pair_t p;
    if (!rst && stick_if.valid && stick_if.ready) begin
      if (expected_sticks.size() == 0) begin
        report_mismatch("unexpected stick beat x", int'(stick_if.stick_x_out), -1);
      end else begin
        p = expected_sticks.pop_front();
        if (stick_if.stick_x_out !== p.x)
          report_mismatch("stick_x_out", int'(stick_if.stick_x_out), int'(p.x));
        if (stick_if.stick_y_out !== p.y)
          report_mismatch("stick_y_out", int'(stick_if.stick_y_out), int'(p.y));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    stick_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** mouse_to_stick_converter: FAILED **");
      $finish;
    end
  end

  // -------------------------------------------------------------- drivers
  task automatic send_frame(frame_row_t f);
    if ($urandom_range(99) < send_idle) begin
      frame_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    typed_fifo.push_back(f);
    frame_if.motion_x    <= f.mx;
    frame_if.motion_y    <= f.my;
    frame_if.wheel_delta <= f.wh;
    frame_if.time_now    <= f.stamp;
    frame_if.stick_x_in  <= f.sx;
    frame_if.stick_y_in  <= f.sy;
    frame_if.valid       <= 1'b1;
    do @(posedge clk); while (!frame_if.ready);
  endtask

  // hold off until every stick beat is in, then let the pipeline settle
  task automatic drain_out();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_sticks.size() != 0 || typed_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[21:0];
    @(posedge clk);
    case (idx)
      REG_SENS:   gain_cfg   = val & 64'hFFFF;
      REG_ADZ:    floor_cfg  = val & 64'hFFFF;
      REG_WEIGHT: weight_cfg = val & 64'hFFFF;
      REG_PLEN:   plen_cfg   = val & 64'hFFFFF;
      REG_QLIMIT: qlimit_cfg = val & 64'h3FFFFF;
      default: ;
    endcase
  endtask

  task automatic load_regs(longint unsigned s, longint unsigned a, longint unsigned w,
                           longint unsigned pl, longint unsigned ql);
    write_reg(REG_SENS, s);
    write_reg(REG_ADZ, a);
    write_reg(REG_WEIGHT, w);
    write_reg(REG_PLEN, pl);
    write_reg(REG_QLIMIT, ql);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(longint mx, longint my, longint wh, longint unsigned stamp,
                         int sx, int sy, bit typed, int ex, int ey);
    frame_row_t f;
    f.mx = MOTION_W'(mx); f.my = MOTION_W'(my); f.wh = WHEEL_W'(wh);
    f.stamp = STAMP_W'(stamp);
    f.sx = BYTE_W'(sx); f.sy = BYTE_W'(sy); f.typed = typed;
    f.ex = BYTE_W'(ex); f.ey = BYTE_W'(ey);
    directed_rows.push_back(f);
  endtask

  function automatic longint rand_motion();
    case ($urandom_range(9))
      0:       return 0;
      1:       return ($urandom_range(1)) ? 8388607 : -8388608;
      2, 3:    return longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
      default: return longint'($urandom_range(0, 400)) - 200;
    endcase
  endfunction

  function automatic longint rand_wheel();
    case ($urandom_range(9))
      0, 1, 2, 3: return 0;
      4, 5:       return 120 * (longint'($urandom_range(0, 6)) - 3);
      6:          return longint'($signed($urandom_range(0, 16'hFFFF) << 16)) >>> 16;
      default:    return longint'($urandom_range(0, 300)) - 150;
    endcase
  endfunction

  // ----------------------------------------------------------------- main
  initial begin
    frame_row_t f;
    longint unsigned clock_us;
    int sel;
    err_count = 0;
    send_idle = 0;
    recv_idle = 0;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SENS;
    cfg_data  = '0;
    frame_if.valid       = 1'b0;
    frame_if.motion_x    = '0;
    frame_if.motion_y    = '0;
    frame_if.wheel_delta = '0;
    frame_if.time_now    = '0;
    frame_if.stick_x_in  = 8'd128;
    frame_if.stick_y_in  = 8'd128;

    // curve table: q^1.25 in q16
    for (int i = 0; i <= DEPTH; i++) begin
      longint unsigned q;
      q = (longint'(i) << 16) / DEPTH;
      shape_tab[i] = (q * floor_root(floor_root(q << 16) << 16)) >> 16;
    end
    gain_cfg = 256; floor_cfg = 7864; weight_cfg = 45875;
    plen_cfg = 70000; qlimit_cfg = 280000;
    last_stamp = 0; pulse_until = 0;
    glide_x = 0; glide_y = 0; wheel_left = 0; pulse_dir = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames, reset register values
    add_row(0, 0, 0, 1000, 128, 128, 1, 128, 128);          // first frame, still mouse
    add_row(8388607, 8388607, 0, 5000, 128, 128, 0, 0, 0);
    add_row(-8388608, -8388608, 0, 5001, 128, 128, 0, 0, 0); // frame time floor
    add_row(8388607, -8388608, 0, 300000, 0, 255, 1, 0, 255); // ceiling, pass-through
    add_row(1, 0, 0, 304000, 128, 128, 0, 0, 0);
    add_row(0, -1, 0, 308000, 128, 128, 0, 0, 0);
    add_row(0, 0, 120, 312000, 7, 128, 1, 7, 0);             // up pulse
    add_row(0, 0, -240, 316000, 9, 128, 1, 9, 255);          // down pulse from now
    add_row(0, 0, 32767, 320000, 128, 128, 0, 0, 0);         // wheel overflow
    add_row(0, 0, -32768, 324000, 128, 128, 0, 0, 0);
    add_row(0, 0, 60, 328000, 128, 128, 0, 0, 0);
    add_row(0, 0, 60, 332000, 128, 128, 0, 0, 0);            // remainder completes
    add_row(0, 0, 120, 336000, 128, 128, 0, 0, 0);           // extends same way
    add_row(5, 5, 0, 0, 255, 0, 1, 255, 0);                  // zero stamp
    add_row(100, -100, 0, 2000, 128, 128, 0, 0, 0);          // first frame again
    add_row(100, -100, 0, 1000, 128, 128, 0, 0, 0);          // time backwards
    add_row(-3, 7, 0, 48'hFFFF_FFFF_FFFF, 127, 129, 0, 0, 0);
    add_row(10, 10, -120, 5, 128, 128, 0, 0, 0);             // stamp wraps
    add_row(0, 0, 0, 48'hAAAA_5555_AAAA, 128, 128, 0, 0, 0);
    add_row(0, 0, 0, 48'h5555_AAAA_5555, 128, 128, 0, 0, 0);
    foreach (directed_rows[i]) send_frame(directed_rows[i]);
    drain_out();

    clock_us = 1000;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_regs(256, 7864, 45875, 70000, 280000);
        1: load_regs(65535, 65535, 65535, 1000000, 4000000);   // upper extremes
        2: load_regs(0, 0, 0, 1, 1);                           // lower extremes
        default: begin
          write_reg(REG_UNUSED, $urandom_range(0, 22'h3FFFFF)); // ignored index
          load_regs($urandom_range(0, 1023), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(1, 300000),
                    $urandom_range(1, 600000));
        end
      endcase
      case (phase % 3)
        0: begin send_idle = 30; recv_idle = 82; end
        1: begin send_idle = 82; recv_idle = 30; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_out();   // sender waits for every beat
        sel = $urandom_range(99);
        if (sel < 3) clock_us = {$urandom, $urandom} & STAMP_MASK;
        else if (sel < 4) clock_us = 0;
        else if (sel < 6) clock_us = (clock_us - $urandom_range(1, 5000)) & STAMP_MASK;
        else clock_us = (clock_us + $urandom_range(300, 30000)) & STAMP_MASK;
        f.mx    = MOTION_W'(rand_motion());
        f.my    = MOTION_W'(rand_motion());
        f.wh    = WHEEL_W'(rand_wheel());
        f.stamp = STAMP_W'(clock_us);
        f.sx    = ($urandom_range(1)) ? 8'd128 : 8'($urandom_range(0, 255));
        f.sy    = ($urandom_range(1)) ? 8'd128 : 8'($urandom_range(0, 255));
        f.typed = 1'b0;
        f.ex    = '0;
        f.ey    = '0;
        send_frame(f);
      end
      drain_out();
    end

    if (err_count == 0) begin
      $display("** mouse_to_stick_converter: PASSED **");
    end else begin
      $display("** mouse_to_stick_converter: FAILED **");
    end
    $finish;
  end

endmodule
